// ===== rtl/core/lcc_pkg.sv =====
// lcc_pkg: shared types, constants and helpers for the commit id cache.
// No dependencies; imported by lcc_store and lru_commit_id_cache.
`timescale 1ns / 1ps

package lcc_pkg;

	localparam int XID_W            = 32;
	localparam int CFG_W            = 7;
	localparam int DEFAULT_CAPACITY = 64;
	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

	typedef enum logic {
		CMD_FIND = 1'b0,
		CMD_ADD  = 1'b1
	} lcc_cmd_t;

	// step outcome from the store to the top level
	typedef struct packed {
		logic             hit;
		logic             dup;
		logic             evict;
		logic             insert;
		logic [XID_W-1:0] ev_key;
	} lcc_status_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (&v) ? v : v + 32'd1;
	endfunction

endpackage

// ===== rtl/core/lcc_store.sv =====
// lcc_store: fully associative entry store with LRU age ranks.
// Parallel tag match, eviction, insert and rank update in the same cycle; depends on lcc_pkg.
`timescale 1ns / 1ps

module lcc_store
	import lcc_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req,
	input  lcc_cmd_t          cmd,
	input  logic [XID_W-1:0]  key,
	input  logic [XID_W-1:0]  value,
	input  logic [CFG_W-1:0]  max_entries,
	output lcc_status_t       status,
	output logic [XID_W-1:0]  found_value,
	output logic [CNT_W-1:0]  count
);

	localparam int LW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [XID_W-1:0] key_q [CAPACITY];
	logic [IDX_W-1:0] rank_q [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0] count_q;
	logic [XID_W-1:0] val_mem [CAPACITY];
	logic [XID_W-1:0] rd_value_s2;

	logic [CAPACITY-1:0] hit_vec, lru_vec, ev_vec, valid_mid, free_vec, ins_oh;
	logic [IDX_W-1:0] hit_idx, hit_rank, ins_idx, lru_rank;
	logic [XID_W-1:0] ev_key;
	logic hit, do_touch, do_add, do_evict, need_evict;

	always_comb begin
		hit_idx  = '0;
		hit_rank = '0;
		ev_key   = '0;
		ins_idx  = '0;
		lru_rank = IDX_W'(count_q - CNT_W'(1));
		for (int i = 0; i < CAPACITY; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key);
			lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
		end
		hit        = |hit_vec;
		do_touch   = req && (cmd == CMD_FIND) && hit;
		do_add     = req && (cmd == CMD_ADD) && !hit;
		need_evict = (LW'(count_q) >= LW'(max_entries)) || (count_q == CNT_W'(CAPACITY));
		do_evict   = do_add && need_evict;
		ev_vec     = do_evict ? lru_vec : '0;
		valid_mid  = valid_q & ~ev_vec;
		free_vec   = ~valid_mid;
		ins_oh     = free_vec & (~free_vec + CAPACITY'(1));
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_vec[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (ev_vec[i]) begin
				ev_key = ev_key | key_q[i];
			end
			if (ins_oh[i]) begin
				ins_idx = ins_idx | IDX_W'(i);
			end
		end
	end

	assign status.hit    = req && hit;
	assign status.dup    = req && (cmd == CMD_ADD) && hit;
	assign status.evict  = do_evict;
	assign status.insert = do_add && (|ins_oh);
	assign status.ev_key = ev_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (do_touch) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (hit_vec[i]) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_q[i] <= rank_q[i] + IDX_W'(1);
				end
			end
		end else if (do_add) begin
			valid_q <= valid_mid | ins_oh;
			if (!do_evict) begin
				count_q <= count_q + CNT_W'(1);
			end
			for (int i = 0; i < CAPACITY; i++) begin
				if (ins_oh[i]) begin
					rank_q[i] <= '0;
				end else if (valid_mid[i]) begin
					rank_q[i] <= rank_q[i] + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_add && ins_oh[i]) begin
				key_q[i] <= key;
			end
		end
	end

	// value memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_add) begin
			val_mem[ins_idx] <= value;
		end
		rd_value_s2 <= do_touch ? val_mem[hit_idx] : '0;
	end

	assign found_value = rd_value_s2;
	assign count       = count_q;

endmodule

// ===== rtl/core/lru_commit_id_cache.sv =====
// lru_commit_id_cache: LRU cache mapping local transaction ids to distributed ids.
// Top level; depends on lcc_pkg and lcc_store.
//
//   channel   handshake              word
//   request   start & !busy          command, local_xid, distrib_xid
//   result    done (one-cycle pulse) found .. remove_total
//   config    cfg_valid & cfg_ready  cfg_data (max_entries)
//
// One request per clock; busy stays low. An accepted request is registered in valid_s1,
// then its result word is registered with done_s2, and done goes high.
// State updates as the result registers, so back-to-back requests see each other.
// Reset empties the store at once and sets max_entries to 64; no clearing pass.
// Results cannot be stalled; done is a strobe.
`timescale 1ns / 1ps

module lru_commit_id_cache
	import lcc_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             command,
	input  logic [XID_W-1:0] local_xid,
	input  logic [XID_W-1:0] distrib_xid,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             done,
	output logic             found,
	output logic [XID_W-1:0] found_value,
	output logic             duplicate_key,
	output logic             evicted,
	output logic [XID_W-1:0] evicted_key,
	output logic [CFG_W-1:0] occupancy,
	output logic [31:0]      hit_total,
	output logic [31:0]      lookup_total,
	output logic [31:0]      add_total,
	output logic [31:0]      remove_total
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic             valid_s1;
	logic             cmd_s1;
	logic [XID_W-1:0] key_s1, val_s1;
	logic [CFG_W-1:0] max_entries_q;
	logic             done_s2, found_s2, dup_s2, evict_s2;
	logic [XID_W-1:0] ev_key_s2;
	logic [31:0]      hit_q, lookup_q, add_q, remove_q;

	lcc_status_t      st;
	logic [CNT_W-1:0] count;
	logic [LW-1:0]    count_ext;
	logic             req;
	lcc_cmd_t         cmd;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign req       = valid_s1 && (max_entries_q != '0);
	assign cmd       = lcc_cmd_t'(cmd_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_entries_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= command;
			key_s1 <= local_xid;
			val_s1 <= distrib_xid;
		end
	end

	lcc_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cmd         (cmd),
		.key         (key_s1),
		.value       (val_s1),
		.max_entries (max_entries_q),
		.status      (st),
		.found_value (found_value),
		.count       (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2  <= 1'b0;
			hit_q    <= '0;
			lookup_q <= '0;
			add_q    <= '0;
			remove_q <= '0;
		end else begin
			done_s2 <= valid_s1;
			if (req && (cmd == CMD_FIND)) begin
				lookup_q <= sat_inc(lookup_q);
				if (st.hit) begin
					hit_q <= sat_inc(hit_q);
				end
			end
			if (st.insert) begin
				add_q <= sat_inc(add_q);
			end
			if (st.evict) begin
				remove_q <= sat_inc(remove_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		found_s2  <= req && (cmd == CMD_FIND) && st.hit;
		dup_s2    <= st.dup;
		evict_s2  <= st.evict;
		ev_key_s2 <= st.ev_key;
	end

	assign count_ext     = LW'(count);
	assign done          = done_s2;
	assign found         = found_s2;
	assign duplicate_key = dup_s2;
	assign evicted       = evict_s2;
	assign evicted_key   = ev_key_s2;
	assign occupancy     = count_ext[CFG_W-1:0];
	assign hit_total     = hit_q;
	assign lookup_total  = lookup_q;
	assign add_total     = add_q;
	assign remove_total  = remove_q;

endmodule

// ===== rtl/core/lcc_checker.sv =====
// lcc_checker: port-level assertions for lru_commit_id_cache.
// Bound to the top level below; no other dependencies.
`timescale 1ns / 1ps

module lcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        found,
	input logic [31:0] found_value,
	input logic        duplicate_key,
	input logic        evicted,
	input logic [6:0]  occupancy,
	input logic [31:0] hit_total
);

	// every accepted request produces a result once it has passed valid_s1 and done_s2
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("request without result");

	a_dup_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && duplicate_key |-> !evicted && !found)
		else $error("duplicate add also evicted or hit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> found_value == 32'd0)
		else $error("value shown without hit");

	// evict-then-insert leaves occupancy unchanged
	a_evict_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted |-> occupancy == $past(occupancy))
		else $error("occupancy moved on eviction");

	a_hit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> hit_total == $past(hit_total))
		else $error("hit counter moved on miss");

endmodule

bind lru_commit_id_cache lcc_checker u_lcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.found         (found),
	.found_value   (found_value),
	.duplicate_key (duplicate_key),
	.evicted       (evicted),
	.occupancy     (occupancy),
	.hit_total     (hit_total)
);
